FILE: hdl/tmm_pkg.sv
package tmm_pkg;

    localparam int TMM_CORDIC_STEPS = 16;

    typedef logic signed [31:0] q16_t;

    // Angle constants in Q16.16 degrees
    localparam logic [31:0] TMM_FULL    = 32'd23592960;
    localparam logic [31:0] TMM_HALF    = 32'd11796480;
    localparam logic [31:0] TMM_QUARTER = 32'd5898240;

    // pi/180 scaled so that |deg| * K >> 30 gives Q2.30 radians
    localparam logic [38:0] TMM_RAD_K  = 39'd307041563859;
    localparam logic [18:0] TMM_RAD_HI = TMM_RAD_K[38:20];
    localparam logic [19:0] TMM_RAD_LO = TMM_RAD_K[19:0];

    localparam logic signed [33:0] TMM_CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        q16_t       axis_x;
        q16_t       axis_y;
        q16_t       axis_z;
        q16_t [2:0] scale;
        q16_t [2:0] shift;
    } tmm_payload_t;

    typedef struct packed {
        logic                vld;
        logic                flip;
        logic signed [33:0]  z;
    } tmm_ang_t;

    typedef struct packed {
        logic                vld;
        logic signed [18:0]  s16;
        logic signed [19:0]  omc16;
    } tmm_trig_t;

    function automatic logic [29:0] tmm_atan(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            5'd24:   v = 30'd63;
            5'd25:   v = 30'd31;
            5'd26:   v = 30'd15;
            5'd27:   v = 30'd7;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic q16_t tmm_sat32(input logic signed [71:0] v);
        q16_t r;
        if (v > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/trs_model_matrix_core.sv
// Model matrix generator: T * S * R with a Rodrigues rotation about an
// unnormalised axis, by the negated angle, all fields signed Q16.16.
//
// Command channel: present the ten transform fields with start high; the
// transaction is taken on any rising edge where start is high and busy is
// low. busy never rises, so a new transaction may be issued every cycle.
//
// Result channel: done pulses for one cycle with the twelve matrix elements
// (top three rows, fourth column is the translation). There is no back
// pressure; the receiver must take each result in the cycle it appears.
//
// The pipeline from accept to done has 4 stages of angle reduction and
// degree-to-radian scaling, one stage per CORDIC iteration plus a rounding
// stage, then 6 stages of K^2, sin/cos weighting and row scaling.
// Throughput is one transaction per cycle; every stage is a plain register
// stage with a valid bit alongside.
//
// Reset clears the valid bits only; results in flight at reset are dropped.
module trs_model_matrix_core #(
    parameter int CORDIC_STEPS = tmm_pkg::TMM_CORDIC_STEPS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tmm_pkg::q16_t shift_x,
    input  tmm_pkg::q16_t shift_y,
    input  tmm_pkg::q16_t shift_z,
    input  tmm_pkg::q16_t axis_x,
    input  tmm_pkg::q16_t axis_y,
    input  tmm_pkg::q16_t axis_z,
    input  tmm_pkg::q16_t angle_deg,
    input  tmm_pkg::q16_t scale_x,
    input  tmm_pkg::q16_t scale_y,
    input  tmm_pkg::q16_t scale_z,
    output logic          done,
    output tmm_pkg::q16_t row0_col0,
    output tmm_pkg::q16_t row0_col1,
    output tmm_pkg::q16_t row0_col2,
    output tmm_pkg::q16_t row0_col3,
    output tmm_pkg::q16_t row1_col0,
    output tmm_pkg::q16_t row1_col1,
    output tmm_pkg::q16_t row1_col2,
    output tmm_pkg::q16_t row1_col3,
    output tmm_pkg::q16_t row2_col0,
    output tmm_pkg::q16_t row2_col1,
    output tmm_pkg::q16_t row2_col2,
    output tmm_pkg::q16_t row2_col3
);
    import tmm_pkg::*;

    localparam int STEPS_EFF = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int DLY       = STEPS_EFF + 5;

    tmm_ang_t     ang;
    tmm_trig_t    trig;
    tmm_payload_t pay_in;
    tmm_payload_t dly_reg [DLY];
    q16_t         elem [3][3];
    q16_t         shift [3];

    assign busy = 1'b0;

    assign pay_in.axis_x   = axis_x;
    assign pay_in.axis_y   = axis_y;
    assign pay_in.axis_z   = axis_z;
    assign pay_in.scale[0] = scale_x;
    assign pay_in.scale[1] = scale_y;
    assign pay_in.scale[2] = scale_z;
    assign pay_in.shift[0] = shift_x;
    assign pay_in.shift[1] = shift_y;
    assign pay_in.shift[2] = shift_z;

    // Hold the matrix operands alongside the sin/cos pipeline
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= pay_in;
        for (int i = 1; i < DLY; i++)
            dly_reg[i] <= dly_reg[i-1];
    end

    tmm_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (start & ~busy),
        .angle_deg (angle_deg),
        .ang       (ang)
    );

    tmm_cordic #(
        .STEPS (STEPS_EFF)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ang   (ang),
        .trig  (trig)
    );

    tmm_mat u_mat (
        .clk     (clk),
        .rst_n   (rst_n),
        .trig    (trig),
        .pay     (dly_reg[DLY-1]),
        .out_vld (done),
        .elem    (elem),
        .shift   (shift)
    );

    assign row0_col0 = elem[0][0];
    assign row0_col1 = elem[0][1];
    assign row0_col2 = elem[0][2];
    assign row0_col3 = shift[0];
    assign row1_col0 = elem[1][0];
    assign row1_col1 = elem[1][1];
    assign row1_col2 = elem[1][2];
    assign row1_col3 = shift[1];
    assign row2_col0 = elem[2][0];
    assign row2_col1 = elem[2][1];
    assign row2_col2 = elem[2][2];
    assign row2_col3 = shift[2];

endmodule

FILE: hdl/tmm_angle.sv
module tmm_angle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  tmm_pkg::q16_t      angle_deg,
    output tmm_pkg::tmm_ang_t  ang
);
    import tmm_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               n1_reg;
    logic [27:0]        r1_reg;
    logic [27:0]        r1_next;
    logic [22:0]        mag2_reg, mag2_next;
    logic               negz2_reg, negz2_next, flip2_reg, flip2_next;
    logic [41:0]        ph3_reg;
    logic [42:0]        pl3_reg;
    logic               negz3_reg, flip3_reg;
    logic signed [33:0] z4_reg, z4_next;
    logic               flip4_reg;
    logic signed [32:0] neg;
    logic [32:0]        mag_in;

    // Stage 1: negate, take magnitude, strip multiples of 64..8 full turns
    always_comb
    begin
        logic [31:0] r;
        neg    = 33'sd0 - {angle_deg[31], angle_deg};
        mag_in = neg[32] ? 33'(33'sd0 - neg) : 33'(neg);
        r      = mag_in[31:0];
        for (int k = 6; k >= 3; k--)
        begin
            if (r >= (TMM_FULL << k))
                r = r - (TMM_FULL << k);
        end
        r1_next = r[27:0];
    end

    // Stage 2: finish the reduction, fold into [-90, 90]
    always_comb
    begin
        logic [27:0]        r;
        logic signed [26:0] th;
        r = r1_reg;
        for (int k = 2; k >= 0; k--)
        begin
            if (r >= 28'(TMM_FULL << k))
                r = r - 28'(TMM_FULL << k);
        end
        if (n1_reg && (r != 28'd0))
            th = 27'(TMM_FULL) - 27'(r);
        else
            th = 27'(r);
        if (th >= 27'(TMM_HALF))
            th = th - 27'(TMM_FULL);
        flip2_next = 1'b0;
        if (th > $signed(27'(TMM_QUARTER)))
        begin
            th         = th - 27'(TMM_HALF);
            flip2_next = 1'b1;
        end
        else if (th < -$signed(27'(TMM_QUARTER)))
        begin
            th         = th + 27'(TMM_HALF);
            flip2_next = 1'b1;
        end
        negz2_next = th[26];
        mag2_next  = th[26] ? 23'(27'sd0 - th) : th[22:0];
    end

    // Stage 4: recombine partial products into Q2.30 radians
    always_comb
    begin
        logic [61:0] sum;
        logic [31:0] zm;
        sum     = {ph3_reg, 20'd0} + 62'(pl3_reg);
        zm      = sum[61:30];
        z4_next = negz3_reg ? 34'(34'sd0 - $signed({2'b00, zm})) : $signed({2'b00, zm});
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= neg[32];
        r1_reg    <= r1_next;
        mag2_reg  <= mag2_next;
        negz2_reg <= negz2_next;
        flip2_reg <= flip2_next;
        ph3_reg   <= 42'(mag2_reg) * 42'(TMM_RAD_HI);
        pl3_reg   <= 43'(mag2_reg) * 43'(TMM_RAD_LO);
        negz3_reg <= negz2_reg;
        flip3_reg <= flip2_reg;
        z4_reg    <= z4_next;
        flip4_reg <= flip3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign ang.vld  = v4_reg;
    assign ang.flip = flip4_reg;
    assign ang.z    = z4_reg;

endmodule

FILE: hdl/tmm_cordic.sv
module tmm_cordic #(
    parameter int STEPS = tmm_pkg::TMM_CORDIC_STEPS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tmm_pkg::tmm_ang_t   ang,
    output tmm_pkg::tmm_trig_t  trig
);
    import tmm_pkg::*;

    logic signed [33:0] x_reg [STEPS];
    logic signed [33:0] y_reg [STEPS];
    logic signed [33:0] z_reg [STEPS];
    logic signed [33:0] x_next [STEPS];
    logic signed [33:0] y_next [STEPS];
    logic signed [33:0] z_next [STEPS];
    logic               f_reg [STEPS];
    logic [STEPS-1:0]   v_reg;
    logic signed [18:0] s16_reg, s16_next;
    logic signed [19:0] omc_reg, omc_next;
    logic               vo_reg;

    // One micro-rotation per stage
    always_comb
    begin
        logic signed [33:0] xs, ys, zs;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                xs = TMM_CORDIC_X0;
                ys = 34'sd0;
                zs = ang.z;
            end
            else
            begin
                xs = x_reg[i-1];
                ys = y_reg[i-1];
                zs = z_reg[i-1];
            end
            if (!zs[33])
            begin
                x_next[i] = xs - (ys >>> i);
                y_next[i] = ys + (xs >>> i);
                z_next[i] = zs - $signed({4'd0, tmm_atan(5'(i))});
            end
            else
            begin
                x_next[i] = xs + (ys >>> i);
                y_next[i] = ys - (xs >>> i);
                z_next[i] = zs + $signed({4'd0, tmm_atan(5'(i))});
            end
        end
    end

    // Undo the fold, round to Q16.16
    always_comb
    begin
        logic signed [33:0] sn, cs;
        logic signed [34:0] s_sum;
        logic signed [35:0] o_sum;
        sn       = f_reg[STEPS-1] ? 34'sd0 - y_reg[STEPS-1] : y_reg[STEPS-1];
        cs       = f_reg[STEPS-1] ? 34'sd0 - x_reg[STEPS-1] : x_reg[STEPS-1];
        s_sum    = 35'(sn) + 35'sd8192;
        o_sum    = 36'sd1073741824 - 36'(cs) + 36'sd8192;
        s16_next = s_sum[32:14];
        omc_next = o_sum[33:14];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
            f_reg[i] <= (i == 0) ? ang.flip : f_reg[(i == 0) ? 0 : i-1];
        end
        s16_reg <= s16_next;
        omc_reg <= omc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v_reg  <= {v_reg[STEPS-2:0], ang.vld};
            vo_reg <= v_reg[STEPS-1];
        end
    end

    assign trig.vld   = vo_reg;
    assign trig.s16   = s16_reg;
    assign trig.omc16 = omc_reg;

endmodule

FILE: hdl/tmm_mat.sv
module tmm_mat (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmm_pkg::tmm_trig_t    trig,
    input  tmm_pkg::tmm_payload_t pay,
    output logic                  out_vld,
    output tmm_pkg::q16_t         elem [3][3],
    output tmm_pkg::q16_t         shift [3]
);
    import tmm_pkg::*;

    logic [5:0]          v_reg;
    tmm_payload_t        p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [18:0]  s1_reg, s2_reg;
    logic signed [19:0]  o1_reg, o2_reg;
    logic signed [63:0]  sqx_reg, sqy_reg, sqz_reg, pxy_reg, pyz_reg, pxz_reg;
    q16_t                k2_reg [3][3];
    q16_t                k2_next [3][3];
    logic signed [32:0]  k_reg [3][3];
    logic signed [32:0]  k_next [3][3];
    logic signed [51:0]  pa_reg [3][3];
    logic signed [51:0]  pb_reg [3][3];
    q16_t                r_reg [3][3];
    logic signed [63:0]  ps_reg [3][3];
    q16_t                out_reg [3][3];

    // K^2 entries and the skew matrix itself
    always_comb
    begin
        logic signed [32:0] kx, ky, kz;
        kx = 33'(p1_reg.axis_x);
        ky = 33'(p1_reg.axis_y);
        kz = 33'(p1_reg.axis_z);
        k_next[0][0] = 33'sd0;
        k_next[0][1] = 33'sd0 - kz;
        k_next[0][2] = ky;
        k_next[1][0] = kz;
        k_next[1][1] = 33'sd0;
        k_next[1][2] = 33'sd0 - kx;
        k_next[2][0] = 33'sd0 - ky;
        k_next[2][1] = kx;
        k_next[2][2] = 33'sd0;
        k2_next[0][0] = tmm_sat32(72'(((66'sd0 - 66'(sqz_reg)) >>> 16)
                                    + ((66'sd0 - 66'(sqy_reg)) >>> 16)));
        k2_next[1][1] = tmm_sat32(72'(((66'sd0 - 66'(sqz_reg)) >>> 16)
                                    + ((66'sd0 - 66'(sqx_reg)) >>> 16)));
        k2_next[2][2] = tmm_sat32(72'(((66'sd0 - 66'(sqy_reg)) >>> 16)
                                    + ((66'sd0 - 66'(sqx_reg)) >>> 16)));
        k2_next[0][1] = tmm_sat32(72'(pxy_reg >>> 16));
        k2_next[1][0] = tmm_sat32(72'(pxy_reg >>> 16));
        k2_next[0][2] = tmm_sat32(72'(pxz_reg >>> 16));
        k2_next[2][0] = tmm_sat32(72'(pxz_reg >>> 16));
        k2_next[1][2] = tmm_sat32(72'(pyz_reg >>> 16));
        k2_next[2][1] = tmm_sat32(72'(pyz_reg >>> 16));
    end

    always_ff @(posedge clk)
    begin
        q16_t ax, ay, az;
        ax = pay.axis_x;
        ay = pay.axis_y;
        az = pay.axis_z;
        // Stage 1: axis products
        p1_reg  <= pay;
        s1_reg  <= trig.s16;
        o1_reg  <= trig.omc16;
        sqx_reg <= 64'(ax) * 64'(ax);
        sqy_reg <= 64'(ay) * 64'(ay);
        sqz_reg <= 64'(az) * 64'(az);
        pxy_reg <= 64'(ax) * 64'(ay);
        pyz_reg <= 64'(ay) * 64'(az);
        pxz_reg <= 64'(ax) * 64'(az);
        // Stage 2: K^2
        p2_reg  <= p1_reg;
        s2_reg  <= s1_reg;
        o2_reg  <= o1_reg;
        k2_reg  <= k2_next;
        k_reg   <= k_next;
        p3_reg  <= p2_reg;
        p4_reg  <= p3_reg;
        p5_reg  <= p4_reg;
        p6_reg  <= p5_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // Stage 3: weight by (1 - cos) and sin
                pa_reg[i][j] <= 52'(o2_reg) * 52'(k2_reg[i][j]);
                pb_reg[i][j] <= 52'(s2_reg) * 52'(k_reg[i][j]);
                // Stage 4: sum with identity
                r_reg[i][j]  <= tmm_sat32(((i == j) ? 72'sd65536 : 72'sd0)
                                          + 72'(tmm_sat32(72'(pa_reg[i][j] >>> 16)))
                                          + 72'(tmm_sat32(72'(pb_reg[i][j] >>> 16))));
                // Stage 5 and 6: scale the row
                ps_reg[i][j]  <= 64'(p4_reg.scale[i]) * 64'(r_reg[i][j]);
                out_reg[i][j] <= tmm_sat32(72'(ps_reg[i][j] >>> 16));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], trig.vld};
    end

    assign out_vld = v_reg[5];
    assign elem    = out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            shift[i] = p6_reg.shift[i];
    end

endmodule
